@@ hw/rtl/rhmw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhmw_pkg
// Shared types, constants and helpers of the right-hand maze walker.
// ----------------------------------------------------------------------------
package rhmw_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;

	localparam int COORD_W    = 6;
	localparam int DIM_W      = 7;
	localparam int HEAD_W     = 2;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// wall map: one row per word, rows split into even and odd banks
	localparam int ROW_W      = MAX_WIDTH;
	localparam int BANK_DEPTH = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_STEP    = 2'd2
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH    = 3'd0,
		REG_GRID_HEIGHT   = 3'd1,
		REG_START_X       = 3'd2,
		REG_START_Y       = 3'd3,
		REG_START_HEADING = 3'd4,
		REG_GOAL_X        = 3'd5,
		REG_GOAL_Y        = 3'd6
	} cfg_reg_e;

	typedef enum logic [HEAD_W-1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_e;

	// heading offsets in the order the walker tries them
	localparam logic [HEAD_W-1:0] TURN_RIGHT = 2'd1;
	localparam logic [HEAD_W-1:0] TURN_LEFT  = 2'd3;
	localparam logic [HEAD_W-1:0] TURN_BACK  = 2'd2;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [HEAD_W-1:0]  head_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [BANK_AW-1:0] bank_addr_t;

	function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
		dim_t r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/rhmw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhmw_cmd_if / rhmw_rsp_if
// Valid/ready channels carrying walker commands and walker results.
// ----------------------------------------------------------------------------
interface rhmw_cmd_if import rhmw_pkg::*; ();
	logic   valid;
	logic   ready;
	logic [CMD_W-1:0] command;
	coord_t cell_x;
	coord_t cell_y;
	logic   is_wall;

	modport source (output valid, command, cell_x, cell_y, is_wall, input ready);
	modport sink   (input valid, command, cell_x, cell_y, is_wall, output ready);
endinterface

interface rhmw_rsp_if import rhmw_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	head_t  heading;
	logic   moved;
	logic   at_goal;
	logic   trapped;

	modport source (output valid, pos_x, pos_y, heading, moved, at_goal, trapped,
		input ready);
	modport sink   (input valid, pos_x, pos_y, heading, moved, at_goal, trapped,
		output ready);
endinterface

@@ hw/rtl/right_hand_maze_walker_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: an accepted item passes the s1 register, the map read into s2 and
// the result register before its result is offered.
// Throughput: one item per cycle while results are taken; an item that follows
// a step or restart waits in s1 until the walker is updated.
// Reset: walker at (0,0) heading up, registers at their defaults; the map is
// cleared one row of each bank at a time, during which no item is accepted.
// ----------------------------------------------------------------------------
// right_hand_maze_walker_unit
// Wall map in two row banks plus walker state, stepping by the right-hand rule.
// ----------------------------------------------------------------------------
module right_hand_maze_walker_unit import rhmw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rhmw_cmd_if.sink              cmd,
	rhmw_rsp_if.source            rsp
);

	// configuration
	dim_t   grid_width_q, grid_height_q;
	coord_t start_x_q, start_y_q, goal_x_q, goal_y_q;
	head_t  start_heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= DIM_W'(16);
			grid_height_q   <= DIM_W'(16);
			start_x_q       <= '0;
			start_y_q       <= '0;
			start_heading_q <= DIR_UP;
			goal_x_q        <= COORD_W'(15);
			goal_y_q        <= COORD_W'(15);
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_GRID_WIDTH:    grid_width_q    <= cfg_wdata[DIM_W-1:0];
				REG_GRID_HEIGHT:   grid_height_q   <= cfg_wdata[DIM_W-1:0];
				REG_START_X:       start_x_q       <= cfg_wdata[COORD_W-1:0];
				REG_START_Y:       start_y_q       <= cfg_wdata[COORD_W-1:0];
				REG_START_HEADING: start_heading_q <= cfg_wdata[HEAD_W-1:0];
				REG_GOAL_X:        goal_x_q        <= cfg_wdata[COORD_W-1:0];
				REG_GOAL_Y:        goal_y_q        <= cfg_wdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	dim_t grid_w, grid_h;
	assign grid_w = clamp_dim(grid_width_q, DIM_W'(MAX_WIDTH));
	assign grid_h = clamp_dim(grid_height_q, DIM_W'(MAX_HEIGHT));

	// map clearing after reset
	logic       clear_busy_q;
	bank_addr_t clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clear_busy_q) begin
			clr_cnt_q <= clr_cnt_q + BANK_AW'(1);
			if (clr_cnt_q == BANK_AW'(BANK_DEPTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	// pipeline control
	logic             valid_s1, valid_s2, out_valid_q;
	logic [CMD_W-1:0] cmd_s1, cmd_s2;
	coord_t           cell_x_s1, cell_y_s1;
	logic             is_wall_s1;
	logic             out_free, s2_adv, s1_adv, walker_busy, accept;

	assign out_free    = !out_valid_q || rsp.ready;
	assign s2_adv      = valid_s2 && out_free;
	// a step or restart in s2 changes the walker the next step must read from
	assign walker_busy = valid_s2 && (cmd_s2 == CMD_STEP || cmd_s2 == CMD_RESTART);
	assign s1_adv      = valid_s1 && (!valid_s2 || s2_adv) && !walker_busy;
	assign cmd.ready   = !clear_busy_q && (!valid_s1 || s1_adv);
	assign accept      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd.command;
			cell_x_s1  <= cmd.cell_x;
			cell_y_s1  <= cmd.cell_y;
			is_wall_s1 <= cmd.is_wall;
		end
		if (s1_adv) begin
			cmd_s2 <= cmd_s1;
		end
	end

	// walker state
	coord_t walker_x_q, walker_y_q;
	head_t  walker_heading_q;

	// map banks: bank b holds rows with y[0] == b
	logic       map_wr, wr_bank;
	bank_addr_t wr_addr;
	row_t       wr_mask;
	coord_t     y_m1;
	dim_t       y_p1;
	row_t       rd_a [2];
	row_t       rd_b [2];

	assign map_wr  = s1_adv && cmd_s1 == CMD_WRITE
		&& (DIM_W'(cell_x_s1) < DIM_W'(MAX_WIDTH))
		&& (DIM_W'(cell_y_s1) < DIM_W'(MAX_HEIGHT));
	assign wr_bank = cell_y_s1[0];
	assign wr_addr = BANK_AW'(cell_y_s1 >> 1);
	assign wr_mask = ROW_W'(1) << cell_x_s1;
	assign y_m1    = walker_y_q - COORD_W'(1);
	assign y_p1    = DIM_W'(walker_y_q) + DIM_W'(1);

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic       same_par, we;
		bank_addr_t waddr, ra, rb;
		row_t       wdata, wmask;

		assign same_par = (walker_y_q[0] == 1'(b));
		assign we       = clear_busy_q || (map_wr && wr_bank == 1'(b));
		assign waddr    = clear_busy_q ? clr_cnt_q : wr_addr;
		assign wdata    = clear_busy_q ? '0 : {ROW_W{is_wall_s1}};
		assign wmask    = clear_busy_q ? '1 : wr_mask;
		assign ra       = same_par ? BANK_AW'(walker_y_q >> 1) : BANK_AW'(y_m1 >> 1);
		assign rb       = BANK_AW'(y_p1 >> 1);

		rhmw_ram #(
			.WIDTH (ROW_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk     (clk),
			.we      (we),
			.waddr   (waddr),
			.wdata   (wdata),
			.wmask   (wmask),
			.re      (s1_adv),
			.raddr_a (ra),
			.raddr_b (rb),
			.rdata_a (rd_a[b]),
			.rdata_b (rd_b[b])
		);
	end

	// step decision in s2; walker is unchanged since the read was issued
	row_t   row_c, row_up, row_dn;
	dim_t   x7, y7;
	coord_t x_p1, x_m1;
	logic [3:0] open_dir;
	coord_t nbr_x [4];
	coord_t nbr_y [4];
	head_t  d_r, d_s, d_l, d_b, d_take;
	logic   any_open, on_goal;

	assign row_c  = rd_a[walker_y_q[0]];
	assign row_up = rd_a[~walker_y_q[0]];
	assign row_dn = rd_b[~walker_y_q[0]];
	assign x7     = DIM_W'(walker_x_q);
	assign y7     = DIM_W'(walker_y_q);
	assign x_p1   = walker_x_q + COORD_W'(1);
	assign x_m1   = walker_x_q - COORD_W'(1);

	assign open_dir[DIR_UP] = (walker_y_q != '0) && (x7 < grid_w)
		&& ((y7 - DIM_W'(1)) < grid_h) && !row_up[walker_x_q];
	assign open_dir[DIR_DOWN] = (x7 < grid_w) && (y_p1 < grid_h)
		&& !row_dn[walker_x_q];
	assign open_dir[DIR_RIGHT] = ((x7 + DIM_W'(1)) < grid_w) && (y7 < grid_h)
		&& !row_c[x_p1];
	assign open_dir[DIR_LEFT] = (walker_x_q != '0) && ((x7 - DIM_W'(1)) < grid_w)
		&& (y7 < grid_h) && !row_c[x_m1];

	assign nbr_x[DIR_UP]    = walker_x_q;
	assign nbr_y[DIR_UP]    = y_m1;
	assign nbr_x[DIR_DOWN]  = walker_x_q;
	assign nbr_y[DIR_DOWN]  = y_p1[COORD_W-1:0];
	assign nbr_x[DIR_RIGHT] = x_p1;
	assign nbr_y[DIR_RIGHT] = walker_y_q;
	assign nbr_x[DIR_LEFT]  = x_m1;
	assign nbr_y[DIR_LEFT]  = walker_y_q;

	assign d_r      = walker_heading_q + TURN_RIGHT;
	assign d_s      = walker_heading_q;
	assign d_l      = walker_heading_q + TURN_LEFT;
	assign d_b      = walker_heading_q + TURN_BACK;
	assign any_open = |open_dir;
	assign on_goal  = (walker_x_q == goal_x_q) && (walker_y_q == goal_y_q);

	always_comb begin
		if (open_dir[d_r]) begin
			d_take = d_r;
		end else if (open_dir[d_s]) begin
			d_take = d_s;
		end else if (open_dir[d_l]) begin
			d_take = d_l;
		end else begin
			d_take = d_b;
		end
	end

	coord_t nx_c, ny_c;
	head_t  nh_c;
	logic   moved_c, trapped_c;

	always_comb begin
		nx_c      = walker_x_q;
		ny_c      = walker_y_q;
		nh_c      = walker_heading_q;
		moved_c   = 1'b0;
		trapped_c = 1'b0;
		case (cmd_e'(cmd_s2))
			CMD_RESTART: begin
				nx_c = start_x_q;
				ny_c = start_y_q;
				nh_c = start_heading_q;
			end
			CMD_STEP: begin
				if (!on_goal) begin
					if (any_open) begin
						nx_c    = nbr_x[d_take];
						ny_c    = nbr_y[d_take];
						nh_c    = d_take;
						moved_c = 1'b1;
					end else begin
						trapped_c = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walker_x_q       <= '0;
			walker_y_q       <= '0;
			walker_heading_q <= DIR_UP;
		end else if (s2_adv) begin
			walker_x_q       <= nx_c;
			walker_y_q       <= ny_c;
			walker_heading_q <= nh_c;
		end
	end

	// result register
	coord_t pos_x_q, pos_y_q;
	head_t  heading_q;
	logic   moved_q, at_goal_q, trapped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			pos_x_q   <= nx_c;
			pos_y_q   <= ny_c;
			heading_q <= nh_c;
			moved_q   <= moved_c;
			trapped_q <= trapped_c;
			at_goal_q <= (nx_c == goal_x_q) && (ny_c == goal_y_q);
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.pos_x   = pos_x_q;
	assign rsp.pos_y   = pos_y_q;
	assign rsp.heading = heading_q;
	assign rsp.moved   = moved_q;
	assign rsp.at_goal = at_goal_q;
	assign rsp.trapped = trapped_q;

	// checks
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy_q |-> !cmd.ready)
		else $error("item accepted during map clear");

	a_walker_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_adv |=> $stable(walker_x_q) && $stable(walker_y_q)
			&& $stable(walker_heading_q))
		else $error("walker changed under a stalled item");

	a_moved_trapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(moved_q && trapped_q))
		else $error("result both moved and trapped");

	a_moved_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && moved_q |-> (DIM_W'(pos_x_q) < grid_w) && (DIM_W'(pos_y_q) < grid_h))
		else $error("walker moved outside the grid");

	a_step_read_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && cmd_s1 == CMD_STEP |-> !walker_busy)
		else $error("step read issued before walker update");

endmodule

@@ hw/rtl/rhmw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhmw_ram
// Generic RAM: one bit-masked write port, two registered read ports.
// ----------------------------------------------------------------------------
module rhmw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [WIDTH-1:0] wmask,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wmask[i]) begin
					mem[waddr][i] <= wdata[i];
				end
			end
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
